/* rtl/pfrm_pkg.sv */
`timescale 1ns / 1ps

package pfrm_pkg;

    localparam int DATA_W      = 32;
    localparam int PROD_W      = 64;
    localparam int MAX_WINDOWS = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int QTY_W       = 16;

    localparam logic [DATA_W-1:0] U32_MAX   = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] RATE_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] RATE_NONE = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN_A    = 3'd2;

    localparam logic [DATA_W-1:0] RATE_SCALE_RST   = 32'd1000;
    localparam logic [DATA_W-1:0] VOLUME_SCALE_RST = 32'd65536;
    localparam logic [MAX_WINDOWS-1:0][DATA_W-1:0] WIN_LEN_RST =
        {32'd60000, 32'd30000, 32'd5000, 32'd1000};

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_PULSE     = 2'd1,
        OP_RESET_ALL = 2'd2,
        OP_RESET_VOL = 2'd3
    } pfrm_op_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic tick_win;
        logic mul_rate;
        logic div_start;
        logic latch_rate;
        logic mul_vol;
        logic load_out;
    } pfrm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic win_hit;
        logic div_busy;
        logic div_done;
    } pfrm_status_t;

endpackage

/* rtl/pulse_flow_rate_meter.sv */
`timescale 1ns / 1ps

// pulse-counting flow rate meter
// input channel (in_valid/in_ready): op and quantity; op is tick, pulse batch,
// reset-all or reset-volume. each accepted word yields exactly one result word
// on the output channel (out_valid/out_ready): four window rates (-1 until a
// window first closes), volume in mL, pulse count, idle ticks and a mask of
// windows that closed on this word.
// config port: cfg_wr_en/cfg_index/cfg_data; write only while idle (not enforced)
// timing: one word at a time. a non-tick word or a tick that closes no window
// goes from accept through S_WIN and S_VOL to S_OUT; every window that
// closes adds S_MUL, S_DIV and S_WAIT, with the shared radix-2 divider (64 steps)
// behind the 32x32 multiplier. the next word is taken once the result is in
// the output register.
// reset: rates go to -1, counters to zero, registers to their defaults
// stall: a held result stays in the output register; a new word may be taken
// and worked on, but its result waits until the held word leaves

module pulse_flow_rate_meter
    import pfrm_pkg::*;
#(
    parameter int NUM_WINDOWS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [QTY_W-1:0]     quantity,
    // result words
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   rate_w0,
    output logic signed [31:0]   rate_w1,
    output logic signed [31:0]   rate_w2,
    output logic signed [31:0]   rate_w3,
    output logic [DATA_W-1:0]    volume_ml,
    output logic [DATA_W-1:0]    volume_pulse_count,
    output logic [DATA_W-1:0]    idle_ticks,
    output logic [MAX_WINDOWS-1:0] updated_mask,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    // window index width, at least one bit
    localparam int WIN_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

    pfrm_cmd_t                          cmd;
    pfrm_status_t                       status;
    logic [WIN_W-1:0]                   win_idx;
    logic [MAX_WINDOWS-1:0][DATA_W-1:0] rates;

    // sequencer: walks the windows, runs multiply and divide, hands off the result
    pfrm_ctrl #(
        .NUM_WINDOWS (NUM_WINDOWS),
        .WIN_W       (WIN_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .win_idx   (win_idx)
    );

    // counters, config registers, multiplier, divider and output register
    pfrm_datapath #(
        .NUM_WINDOWS (NUM_WINDOWS),
        .WIN_W       (WIN_W)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .win_idx            (win_idx),
        .status             (status),
        .op                 (op),
        .quantity           (quantity),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .rates              (rates),
        .volume_ml          (volume_ml),
        .volume_pulse_count (volume_pulse_count),
        .idle_ticks         (idle_ticks),
        .updated_mask       (updated_mask)
    );

    assign rate_w0 = signed'(rates[0]);
    assign rate_w1 = signed'(rates[1]);
    assign rate_w2 = signed'(rates[2]);
    assign rate_w3 = signed'(rates[3]);

`ifndef SYNTHESIS
    // only one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // the divider is never restarted mid-division
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // a rate is latched only at the end of a division
    a_latch_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_rate |-> $past(status.div_busy))
        else $error("rate latched without a division");
`endif

endmodule

/* rtl/pfrm_div.sv */
`timescale 1ns / 1ps

module pfrm_div
    import pfrm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PROD_W-1:0] dq_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic [DATA_W:0]   rem_shift;
    logic              fits;
    logic [DATA_W:0]   rem_next;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg[DATA_W-1:0], dq_reg[PROD_W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        rem_next  = fits ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[PROD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

/* rtl/pfrm_datapath.sv */
`timescale 1ns / 1ps

module pfrm_datapath
    import pfrm_pkg::*;
#(
    parameter int NUM_WINDOWS = 4,
    parameter int WIN_W       = 2
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pfrm_cmd_t                             cmd,
    input  logic [WIN_W-1:0]                      win_idx,
    output pfrm_status_t                          status,
    input  logic [1:0]                            op,
    input  logic [QTY_W-1:0]                      quantity,
    input  logic                                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [DATA_W-1:0]                     cfg_data,
    output logic [MAX_WINDOWS-1:0][DATA_W-1:0]    rates,
    output logic [DATA_W-1:0]                     volume_ml,
    output logic [DATA_W-1:0]                     volume_pulse_count,
    output logic [DATA_W-1:0]                     idle_ticks,
    output logic [MAX_WINDOWS-1:0]                updated_mask
);

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? U32_MAX : s[DATA_W-1:0];
    endfunction

    // configuration
    logic [DATA_W-1:0] rate_scale_reg;
    logic [DATA_W-1:0] volume_scale_reg;
    logic [DATA_W-1:0] win_len_reg [NUM_WINDOWS];

    // measurement state
    logic [DATA_W-1:0]      elapsed_reg [NUM_WINDOWS];
    logic [DATA_W-1:0]      count_reg   [NUM_WINDOWS];
    logic [DATA_W-1:0]      rate_reg    [NUM_WINDOWS];
    logic [DATA_W-1:0]      total_reg;
    logic [DATA_W-1:0]      since_reg;
    logic [NUM_WINDOWS-1:0] mask_reg;
    logic [1:0]             op_reg;

    // arithmetic
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] elapsed_next;
    logic [DATA_W-1:0] rate_next;
    logic [DATA_W-1:0] vol_next;
    logic [PROD_W-1:0] quotient;
    logic              div_busy;
    logic              div_done;

    // result word
    logic [DATA_W-1:0]      out_rate_reg [NUM_WINDOWS];
    logic [DATA_W-1:0]      out_vol_reg;
    logic [DATA_W-1:0]      out_total_reg;
    logic [DATA_W-1:0]      out_since_reg;
    logic [MAX_WINDOWS-1:0] out_mask_reg;

    logic [CFG_IDX_W-1:0] cfg_win;
    logic                 cfg_win_ok;

    assign cfg_win    = cfg_index - CFG_WIN_LEN_A;
    assign cfg_win_ok = (cfg_index >= CFG_WIN_LEN_A) && (cfg_win < CFG_IDX_W'(NUM_WINDOWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_scale_reg   <= RATE_SCALE_RST;
            volume_scale_reg <= VOLUME_SCALE_RST;
            for (int i = 0; i < NUM_WINDOWS; i++)
            begin
                win_len_reg[i] <= WIN_LEN_RST[i];
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_RATE_SCALE)
            begin
                rate_scale_reg <= cfg_data;
            end
            else if (cfg_index == CFG_VOLUME_SCALE)
            begin
                volume_scale_reg <= cfg_data;
            end
            else if (cfg_win_ok)
            begin
                win_len_reg[cfg_win[WIN_W-1:0]] <= cfg_data;
            end
        end
    end

    // window step: saturating elapsed count and length compare
    assign elapsed_next = sat_add(elapsed_reg[win_idx], 32'd1);

    // one shared multiplier for rate product and volume
    assign mul_a     = cmd.mul_rate ? count_reg[win_idx] : total_reg;
    assign mul_b     = cmd.mul_rate ? rate_scale_reg : volume_scale_reg;
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_rate || cmd.mul_vol)
        begin
            prod_reg <= prod_next;
        end
    end

    pfrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (elapsed_reg[win_idx]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign rate_next = (quotient[PROD_W-1:DATA_W-1] != '0) ? RATE_MAX : quotient[DATA_W-1:0];
    assign vol_next  = (prod_reg[PROD_W-1:PROD_W-16] != '0) ? U32_MAX : prod_reg[PROD_W-17:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WINDOWS; i++)
            begin
                elapsed_reg[i] <= '0;
                count_reg[i]   <= '0;
                rate_reg[i]    <= RATE_NONE;
            end
            total_reg <= '0;
            since_reg <= '0;
            mask_reg  <= '0;
            op_reg    <= OP_TICK;
        end
        else
        begin
            if (cmd.load_item)
            begin
                op_reg   <= op;
                mask_reg <= '0;
                unique case (pfrm_op_t'(op))
                    OP_TICK:
                    begin
                        since_reg <= sat_add(since_reg, 32'd1);
                    end
                    OP_PULSE:
                    begin
                        since_reg <= '0;
                        total_reg <= sat_add(total_reg, DATA_W'(quantity));
                        for (int i = 0; i < NUM_WINDOWS; i++)
                        begin
                            count_reg[i] <= sat_add(count_reg[i], DATA_W'(quantity));
                        end
                    end
                    OP_RESET_ALL:
                    begin
                        for (int i = 0; i < NUM_WINDOWS; i++)
                        begin
                            elapsed_reg[i] <= '0;
                            count_reg[i]   <= '0;
                            rate_reg[i]    <= RATE_NONE;
                        end
                        since_reg <= '0;
                        total_reg <= '0;
                    end
                    OP_RESET_VOL:
                    begin
                        total_reg <= '0;
                    end
                    default:
                    begin
                        total_reg <= total_reg;
                    end
                endcase
            end
            if (cmd.tick_win)
            begin
                elapsed_reg[win_idx] <= elapsed_next;
            end
            if (cmd.latch_rate)
            begin
                rate_reg[win_idx]    <= rate_next;
                count_reg[win_idx]   <= '0;
                elapsed_reg[win_idx] <= '0;
                mask_reg[win_idx]    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            for (int i = 0; i < NUM_WINDOWS; i++)
            begin
                out_rate_reg[i] <= rate_reg[i];
            end
            out_vol_reg   <= vol_next;
            out_total_reg <= total_reg;
            out_since_reg <= since_reg;
            out_mask_reg  <= MAX_WINDOWS'(mask_reg);
        end
    end

    for (genvar g = 0; g < MAX_WINDOWS; g++)
    begin : g_rate
        if (g < NUM_WINDOWS)
        begin : g_used
            assign rates[g] = out_rate_reg[g];
        end
        else
        begin : g_unused
            assign rates[g] = RATE_NONE;
        end
    end

    assign volume_ml          = out_vol_reg;
    assign volume_pulse_count = out_total_reg;
    assign idle_ticks         = out_since_reg;
    assign updated_mask       = out_mask_reg;

    assign status.is_tick  = (pfrm_op_t'(op_reg) == OP_TICK);
    assign status.win_hit  = (elapsed_next >= win_len_reg[win_idx]);
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

endmodule

/* rtl/pfrm_ctrl.sv */
`timescale 1ns / 1ps

module pfrm_ctrl
    import pfrm_pkg::*;
#(
    parameter int NUM_WINDOWS = 4,
    parameter int WIN_W       = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pfrm_status_t       status,
    output pfrm_cmd_t          cmd,
    output logic [WIN_W-1:0]   win_idx
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_VOL,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic [WIN_W-1:0] win_reg;
    logic             out_valid_reg;
    logic             last_win;
    logic             out_free;

    assign last_win = (win_reg == WIN_W'(NUM_WINDOWS - 1));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.load_item  = (state_reg == S_IDLE) && in_valid;
        cmd.tick_win   = (state_reg == S_WIN) && status.is_tick;
        cmd.mul_rate   = (state_reg == S_MUL);
        cmd.div_start  = (state_reg == S_DIV);
        cmd.latch_rate = (state_reg == S_WAIT) && status.div_done;
        cmd.mul_vol    = (state_reg == S_VOL);
        cmd.load_out   = (state_reg == S_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        win_reg   <= '0;
                        state_reg <= S_WIN;
                    end
                end
                S_WIN:
                begin
                    if (!status.is_tick)
                    begin
                        state_reg <= S_VOL;
                    end
                    else if (status.win_hit)
                    begin
                        state_reg <= S_MUL;
                    end
                    else if (last_win)
                    begin
                        state_reg <= S_VOL;
                    end
                    else
                    begin
                        win_reg <= win_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (status.div_done)
                    begin
                        if (last_win)
                        begin
                            state_reg <= S_VOL;
                        end
                        else
                        begin
                            win_reg   <= win_reg + 1'b1;
                            state_reg <= S_WIN;
                        end
                    end
                end
                S_VOL:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign win_idx   = win_reg;

endmodule

/* tb/sv/tb_pulse_flow_rate_meter.sv */
`timescale 1ns / 1ps

module tb_pulse_flow_rate_meter;
    import pfrm_pkg::*;

    localparam int WINDOWS          = 4;
    localparam int PHASE_WORDS      = 186;
    localparam int HOLD_OFF_CYCLES  = 1500;
    localparam int HOLD_OFF_AT      = 300;
    localparam int WATCHDOG_LIMIT   = 12000;
    localparam int DRAIN_CYCLES     = 300;

    // one result word, rates packed with window 0 in the low slot
    typedef struct packed {
        logic [MAX_WINDOWS-1:0][DATA_W-1:0] rate;
        logic [DATA_W-1:0]                  volume_ml;
        logic [DATA_W-1:0]                  pulses;
        logic [DATA_W-1:0]                  idle;
        logic [MAX_WINDOWS-1:0]             mask;
    } flow_reading_t;

    // predicts every result word from the accepted input words and holds
    // the readings still owed by the block
    class flow_scoreboard;
        int                active_windows;
        logic [DATA_W-1:0] rate_scale;
        logic [DATA_W-1:0] volume_scale;
        logic [DATA_W-1:0] window_len [MAX_WINDOWS];
        logic [DATA_W-1:0] elapsed [MAX_WINDOWS];
        logic [DATA_W-1:0] window_pulses [MAX_WINDOWS];
        logic [DATA_W-1:0] rate [MAX_WINDOWS];
        logic [DATA_W-1:0] total_pulses;
        logic [DATA_W-1:0] idle_ticks;
        flow_reading_t     expected_readings [$];
        int                failures;
        int                readings;
        int                closes;
        int                clipped;

        function new(int windows);
            active_windows = windows;
            rate_scale     = RATE_SCALE_RST;
            volume_scale   = VOLUME_SCALE_RST;
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                window_len[i] = WIN_LEN_RST[i];
            end
            clear_all();
            failures = 0;
            readings = 0;
            closes   = 0;
            clipped  = 0;
        endfunction

        static function logic [DATA_W-1:0] add_sat(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            logic [DATA_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[DATA_W] ? U32_MAX : s[DATA_W-1:0];
        endfunction

        function void clear_all();
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                elapsed[i]       = '0;
                window_pulses[i] = '0;
                rate[i]          = RATE_NONE;
            end
            total_pulses = '0;
            idle_ticks   = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            if (idx == CFG_RATE_SCALE)
                rate_scale = value;
            else if (idx == CFG_VOLUME_SCALE)
                volume_scale = value;
            else if (idx >= CFG_WIN_LEN_A && int'(idx) < int'(CFG_WIN_LEN_A) + MAX_WINDOWS)
                window_len[idx - CFG_WIN_LEN_A] = value;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            failures++;
        endfunction

        // an accepted input word: advance the state and queue the reading
        function void note_word(logic [1:0] op_code, logic [QTY_W-1:0] qty);
            flow_reading_t     want;
            logic [63:0]       quot;
            logic [63:0]       vol;
            logic [MAX_WINDOWS-1:0] mask;
            mask = '0;
            case (pfrm_op_t'(op_code))
                OP_TICK:
                begin
                    idle_ticks = add_sat(idle_ticks, 1);
                    for (int i = 0; i < active_windows; i++)
                    begin
                        elapsed[i] = add_sat(elapsed[i], 1);
                        // a zero length behaves as one: elapsed is never zero here
                        if (elapsed[i] >= window_len[i])
                        begin
                            quot = ({32'd0, window_pulses[i]} * {32'd0, rate_scale})
                                   / {32'd0, elapsed[i]};
                            if (quot > {32'd0, RATE_MAX})
                            begin
                                rate[i] = RATE_MAX;
                                clipped++;
                            end
                            else
                            begin
                                rate[i] = quot[DATA_W-1:0];
                            end
                            window_pulses[i] = '0;
                            elapsed[i]       = '0;
                            mask[i]          = 1'b1;
                            closes++;
                        end
                    end
                end
                OP_PULSE:
                begin
                    idle_ticks   = '0;
                    total_pulses = add_sat(total_pulses, {16'd0, qty});
                    for (int i = 0; i < active_windows; i++)
                    begin
                        window_pulses[i] = add_sat(window_pulses[i], {16'd0, qty});
                    end
                end
                OP_RESET_ALL:
                begin
                    clear_all();
                end
                default:
                begin
                    total_pulses = '0;
                end
            endcase
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                want.rate[i] = (i < active_windows) ? rate[i] : RATE_NONE;
            end
            vol            = ({32'd0, total_pulses} * {32'd0, volume_scale}) >> 16;
            want.volume_ml = (vol[63:32] != 0) ? U32_MAX : vol[DATA_W-1:0];
            want.pulses    = total_pulses;
            want.idle      = idle_ticks;
            want.mask      = mask;
            expected_readings.insert(expected_readings.size(), want);
        endfunction

        // an accepted result word: compare against the oldest prediction
        function void check_reading(flow_reading_t got);
            flow_reading_t want;
            if (expected_readings.size() == 0)
            begin
                report("result word with no input word waiting for it");
                return;
            end
            want = expected_readings.pop_front();
            readings++;
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                if (got.rate[i] !== want.rate[i])
                    report($sformatf("rate_w%0d got %0d expected %0d", i,
                                     $signed(got.rate[i]), $signed(want.rate[i])));
            end
            if (got.volume_ml !== want.volume_ml)
                report($sformatf("volume_ml got 0x%08h expected 0x%08h",
                                 got.volume_ml, want.volume_ml));
            if (got.pulses !== want.pulses)
                report($sformatf("volume_pulse_count got 0x%08h expected 0x%08h",
                                 got.pulses, want.pulses));
            if (got.idle !== want.idle)
                report($sformatf("idle_ticks got 0x%08h expected 0x%08h",
                                 got.idle, want.idle));
            if (got.mask !== want.mask)
                report($sformatf("updated_mask got %b expected %b", got.mask, want.mask));
        endfunction
    endclass

    // dut signals
    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             op;
    logic [QTY_W-1:0]       quantity;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [31:0]     rate_w0;
    logic signed [31:0]     rate_w1;
    logic signed [31:0]     rate_w2;
    logic signed [31:0]     rate_w3;
    logic [DATA_W-1:0]      volume_ml;
    logic [DATA_W-1:0]      volume_pulse_count;
    logic [DATA_W-1:0]      idle_ticks;
    logic [MAX_WINDOWS-1:0] updated_mask;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    flow_scoreboard meter;
    int             words_in;       // input words accepted so far
    int             settings_used;  // register settings the run went through
    bit             no_idle;        // both sides run flat out while set
    bit             hold_off_done;
    int unsigned    quiet_cycles;

    pulse_flow_rate_meter #(
        .NUM_WINDOWS(WINDOWS)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .quantity           (quantity),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .rate_w0            (rate_w0),
        .rate_w1            (rate_w1),
        .rate_w2            (rate_w2),
        .rate_w3            (rate_w3),
        .volume_ml          (volume_ml),
        .volume_pulse_count (volume_pulse_count),
        .idle_ticks         (idle_ticks),
        .updated_mask       (updated_mask),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // monitor: sampled at the edge, so everything seen is the pre-edge value.
    // a result taken at the same edge as a new word always belongs to an
    // older word, so check first and then note
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && out_ready)
                meter.check_reading({rate_w3, rate_w2, rate_w1, rate_w0, volume_ml,
                                     volume_pulse_count, idle_ticks, updated_mask});
            if (in_valid && in_ready)
            begin
                meter.note_word(op, quantity);
                words_in <= words_in + 1;
            end
        end
    end

    // watchdog: too long with no word moving on either side ends the run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, none while no_idle is set, and one long
    // hold-off so the block fills up and pushes back on the sender
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!hold_off_done && words_in >= HOLD_OFF_AT)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= 31);
        end
    end

    // offer one word; valid stays up with the payload fixed until taken
    task automatic send_word(pfrm_op_t code, logic [QTY_W-1:0] qty);
        while (!no_idle && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        quantity <= qty;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every predicted reading has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (meter.pending() != 0)
            @(posedge clk);
        // every word yields a reading, so the block is idle now; a short margin
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        meter.set_register(idx, value);
    endtask

    // full register setting, written only with nothing in flight
    task automatic apply_setting(logic [DATA_W-1:0] scale, logic [DATA_W-1:0] vol_scale,
                                 logic [DATA_W-1:0] len0, logic [DATA_W-1:0] len1,
                                 logic [DATA_W-1:0] len2, logic [DATA_W-1:0] len3);
        logic [DATA_W-1:0] lens [MAX_WINDOWS];
        lens = '{len0, len1, len2, len3};
        drain();
        write_register(CFG_RATE_SCALE, scale);
        write_register(CFG_VOLUME_SCALE, vol_scale);
        for (int i = 0; i < MAX_WINDOWS; i++)
        begin
            write_register(CFG_WIN_LEN_A + CFG_IDX_W'(i), lens[i]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // pulse counts: mostly small batches, some full range and the extremes
    function automatic logic [QTY_W-1:0] pick_quantity();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        else if (sel < 4)
            return QTY_W'($urandom_range(0, 65535));
        else
            return QTY_W'($urandom_range(1, 50));
    endfunction

    // mostly ticks and pulse batches so windows keep closing; resets now and then
    task automatic send_random(int count);
        int sel;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 56)
                send_word(OP_TICK, QTY_W'($urandom));
            else if (sel < 90)
                send_word(OP_PULSE, pick_quantity());
            else if (sel < 98)
                send_word(OP_RESET_VOL, QTY_W'($urandom));
            else
                send_word(OP_RESET_ALL, QTY_W'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        meter         = new(WINDOWS);
        words_in      = 0;
        settings_used = 1;
        no_idle       = 1'b0;
        hold_off_done = 1'b0;
        quiet_cycles  = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_TICK;
        quantity  <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: quantity ignored on non-pulse words, empty and full batches
        send_word(OP_TICK, 16'hFFFF);
        send_word(OP_PULSE, 16'h0000);
        send_word(OP_PULSE, 16'hFFFF);
        send_word(OP_RESET_VOL, 16'h5A5A);
        send_word(OP_PULSE, 16'h0001);
        send_word(OP_RESET_ALL, 16'hA5A5);

        // extremes: largest scales clip rate and volume, zero length closes
        // on every tick, the longest window never closes
        apply_setting(U32_MAX, U32_MAX, 32'd0, 32'd1, 32'd2, U32_MAX);
        send_word(OP_PULSE, 16'hFFFF);
        send_word(OP_PULSE, 16'hFFFF);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_PULSE, 16'h0003);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_RESET_VOL, 16'h0000);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_RESET_ALL, 16'h0000);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_TICK, 16'h0000);

        // smallest scales: rates truncate, volume stays at zero
        apply_setting(32'd1, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4);
        send_word(OP_PULSE, 16'h0007);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_TICK, 16'h0000);

        // random phases, each under its own register setting
        apply_setting(32'd1000, 32'd65536, 32'd3, 32'd7, 32'd15, 32'd25);
        send_random(PHASE_WORDS);

        apply_setting(32'd1, 32'd0, 32'd1, U32_MAX, 32'd5, 32'd12);
        send_random(PHASE_WORDS);

        apply_setting($urandom, $urandom, $urandom_range(1, 30), $urandom_range(1, 30),
                      $urandom_range(1, 30), $urandom_range(1, 30));
        no_idle = 1'b1;
        send_random(PHASE_WORDS);
        drain();
        no_idle = 1'b0;

        apply_setting(U32_MAX, U32_MAX, 32'd2, 32'd4, 32'd8, 32'd16);
        send_random(PHASE_WORDS);

        apply_setting($urandom_range(1, 100000), $urandom_range(0, 1 << 20),
                      $urandom_range(1, 60), $urandom_range(1, 60),
                      $urandom_range(1, 60), $urandom_range(1, 60));
        send_random(PHASE_WORDS);

        // wait out the last readings, then a margin for any stray word
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d input words under %0d register settings, %0d readings checked",
                 words_in, settings_used, meter.readings);
        $display("run: %0d window closes, %0d of them with a clipped rate",
                 meter.closes, meter.clipped);
        if (meter.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
